// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the generator RTL.
// Depends on nothing; files that assert include it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define PSDES_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked in the cycle after the trigger.
`define PSDES_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/psdes_pkg.sv =====
// Types, codes and round constants of the pseudo-DES counter hash generator.
// Depends on nothing; used by the round cell and the top level.
package psdes_pkg;

  localparam int unsigned NUM_ROUNDS = 4;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned HALF_W     = 16;

  // Operation codes carried on in_func
  typedef enum logic [1:0] {
    FUNC_NEXT32 = 2'd0,
    FUNC_NEXT64 = 2'd1,
    FUNC_HASH   = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  // Configuration register indexes
  localparam logic CFG_START_SEQ = 1'b0;
  localparam logic CFG_START_CTR = 1'b1;

  localparam logic [WORD_W-1:0] MIX_C1 [NUM_ROUNDS] =
    '{32'hBAA96887, 32'h1E17D32C, 32'h03BCDC3C, 32'h0F33D1B2};
  localparam logic [WORD_W-1:0] MIX_C2 [NUM_ROUNDS] =
    '{32'h4B0F3B58, 32'hE874F0C3, 32'h6955C5A6, 32'h55A7CA46};

  // Data handed from one round cell to the next
  typedef struct packed {
    logic              valid;
    func_t             func;
    logic [WORD_W-1:0] a;    // word fed to the next round
    logic [WORD_W-1:0] b;    // word the next round output is XORed into
  } cell_bus_t;

  // One pseudo-DES mixing round
  function automatic logic [WORD_W-1:0] psdes_round(
    input logic [WORD_W-1:0] w,
    input logic [WORD_W-1:0] c1,
    input logic [WORD_W-1:0] c2
  );
    logic [WORD_W-1:0] x;
    logic [HALF_W-1:0] lo;
    logic [HALF_W-1:0] hi;
    logic [WORD_W-1:0] lo_sq;
    logic [WORD_W-1:0] hi_sq;
    logic [WORD_W-1:0] lo_hi;
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] swp;
    x     = w ^ c1;
    lo    = x[HALF_W-1:0];
    hi    = x[WORD_W-1:HALF_W];
    lo_sq = lo * lo;
    hi_sq = hi * hi;
    lo_hi = lo * hi;
    mix   = lo_sq + ~hi_sq;
    swp   = {mix[HALF_W-1:0], mix[WORD_W-1:HALF_W]};
    return (swp ^ c2) + lo_hi;
  endfunction

endpackage

// ===== rtl/core/psdes_round_cell.sv =====
// One round cell of the mixing chain: applies its round and registers the pair.
// Depends on psdes_pkg.
module psdes_round_cell
  import psdes_pkg::*;
#(
  parameter int unsigned RND = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      advance,
  input  cell_bus_t bus_in,
  output cell_bus_t bus_out
);

  cell_bus_t bus_r;
  cell_bus_t bus_nxt;

  // Mix the fed word, fold it into the other word, swap roles
  always_comb begin
    bus_nxt       = bus_in;
    bus_nxt.a     = bus_in.b ^ psdes_round(bus_in.a, MIX_C1[RND], MIX_C2[RND]);
    bus_nxt.b     = bus_in.a;
  end

  // Clear valid under reset, otherwise advance the pair with the chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_r.valid <= 1'b0;
    end else if (advance) begin
      bus_r <= bus_nxt;
    end
  end

  assign bus_out = bus_r;

endmodule

// ===== rtl/core/pseudo_des_counter_hash_rng_top.sv =====
// Top level of the pseudo-DES counter hash generator.
// Depends on psdes_pkg, psdes_round_cell and assert_macros.svh.
// A request passes through four round cells, then the output register, on its
// way to a valid result. Throughput: one item per cycle; each round cell
// holds one item, and the whole chain stalls while a result waits.
// Reset (synchronous, rst_n low) zeroes both state words and empties the chain.
`include "assert_macros.svh"

module pseudo_des_counter_hash_rng_top
  import psdes_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [63:0] in_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  logic [WORD_W-1:0] seq_r;
  logic [WORD_W-1:0] seq_nxt;
  logic [WORD_W-1:0] ctr_r;
  logic [WORD_W-1:0] ctr_nxt;
  logic              out_valid_r;
  logic [63:0]       out_value_r;
  logic [63:0]       out_value_nxt;
  logic              advance;
  logic              in_xfer;
  logic              cfg_xfer;
  func_t             func_in;
  cell_bus_t         bus [NUM_ROUNDS+1];

  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = advance;
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign cfg_xfer  = cfg_valid && cfg_ready;
  assign func_in   = func_t'(in_func);

  // Load state from configuration, otherwise step the counter (carrying into the sequence word) on next-value ops
  always_comb begin
    seq_nxt = seq_r;
    ctr_nxt = ctr_r;
    if (cfg_xfer) begin
      unique case (cfg_index)
        CFG_START_SEQ: seq_nxt = cfg_data;
        CFG_START_CTR: ctr_nxt = cfg_data;
        default: ;
      endcase
    end else if (in_xfer && (func_in == FUNC_NEXT32 || func_in == FUNC_NEXT64)) begin
      ctr_nxt = ctr_r + 32'd1;
      if (ctr_r == '1) begin
        seq_nxt = seq_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '0;
      ctr_r <= '0;
    end else begin
      seq_r <= seq_nxt;
      ctr_r <= ctr_nxt;
    end
  end

  // Feed the chain: counter pair or the given index
  always_comb begin
    bus[0].valid = in_xfer;
    bus[0].func  = func_in;
    if (func_in == FUNC_HASH) begin
      bus[0].a = in_index[WORD_W-1:0];
      bus[0].b = in_index[63:WORD_W];
    end else begin
      bus[0].a = ctr_r;
      bus[0].b = seq_r;
    end
  end

  // Row of round cells
  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_cell
    psdes_round_cell #(
      .RND(g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .bus_in  (bus[g]),
      .bus_out (bus[g+1])
    );
  end

  // Shape the result: last cell holds kk3 in a and kk2 in b
  always_comb begin
    unique case (bus[NUM_ROUNDS].func)
      FUNC_NEXT32: out_value_nxt = {32'd0, bus[NUM_ROUNDS].a};
      FUNC_NEXT64,
      FUNC_HASH:   out_value_nxt = {bus[NUM_ROUNDS].b, bus[NUM_ROUNDS].a};
      default:     out_value_nxt = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= bus[NUM_ROUNDS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

  `PSDES_ASSERT_NEXT(a_ctr_step,
    in_xfer && !cfg_xfer && (func_in == FUNC_NEXT32 || func_in == FUNC_NEXT64),
    ctr_r == 32'($past(ctr_r) + 32'd1), "counter did not advance")
  `PSDES_ASSERT_NEXT(a_seq_carry,
    in_xfer && !cfg_xfer && (func_in == FUNC_NEXT32 || func_in == FUNC_NEXT64)
      && ctr_r == '1,
    seq_r == 32'($past(seq_r) + 32'd1), "sequence word missed counter carry")
  `PSDES_ASSERT_NEXT(a_hash_keeps_state,
    !cfg_xfer && !(in_xfer && (func_in == FUNC_NEXT32 || func_in == FUNC_NEXT64)),
    $stable(seq_r) && $stable(ctr_r), "state changed without next-value op")
  `PSDES_ASSERT(a_stall_holds_chain,
    out_valid_r && !out_ready |-> !in_ready, "chain took input while stalled")

endmodule

// ===== tb/tb_pseudo_des_counter_hash_rng_top.sv =====
// Self-checking testbench for the pseudo-DES counter hash generator top level.
// Depends on psdes_pkg and pseudo_des_counter_hash_rng_top; the expected values
// come from an independent four-round hash predictor kept in a scoreboard class.
module tb_pseudo_des_counter_hash_rng_top;
  timeunit 1ns;
  timeprecision 1ps;
  import psdes_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned PHASE_ITEMS  = 170;
  localparam int unsigned NUM_PHASES   = 5;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned GAP_MAX      = 13;
  localparam int unsigned PRINT_CAP    = 100;

  // Predictor state, expected value queue and mismatch bookkeeping
  class rng_scoreboard;
    logic [31:0] start_seq;
    logic [31:0] start_ctr;
    logic [31:0] seq_word;
    logic [31:0] ctr_word;
    logic [63:0] expected_values[$];
    int unsigned mismatches;

    function new();
      start_seq  = '0;
      start_ctr  = '0;
      seq_word   = '0;
      ctr_word   = '0;
      mismatches = 0;
    endfunction

    // One mixing round: squares of the halves, halfword swap, XOR, add product
    function logic [31:0] mix_round(logic [31:0] w, int unsigned r);
      logic [31:0] key_in;
      logic [31:0] key_out;
      logic [31:0] x;
      logic [31:0] lo;
      logic [31:0] hi;
      logic [31:0] sum;
      case (r)
        0: begin
          key_in  = 32'hBAA96887;
          key_out = 32'h4B0F3B58;
        end
        1: begin
          key_in  = 32'h1E17D32C;
          key_out = 32'hE874F0C3;
        end
        2: begin
          key_in  = 32'h03BCDC3C;
          key_out = 32'h6955C5A6;
        end
        default: begin
          key_in  = 32'h0F33D1B2;
          key_out = 32'h55A7CA46;
        end
      endcase
      x   = w ^ key_in;
      lo  = {16'd0, x[15:0]};
      hi  = {16'd0, x[31:16]};
      sum = lo * lo + ~(hi * hi);
      return ({sum[15:0], sum[31:16]} ^ key_out) + lo * hi;
    endfunction

    // Four chained rounds; high word is the third key, low word the fourth
    function logic [63:0] hash_pair(logic [31:0] seq, logic [31:0] num);
      logic [31:0] k0;
      logic [31:0] k1;
      logic [31:0] k2;
      logic [31:0] k3;
      k0 = seq ^ mix_round(num, 0);
      k1 = num ^ mix_round(k0, 1);
      k2 = k0 ^ mix_round(k1, 2);
      k3 = k1 ^ mix_round(k2, 3);
      return {k2, k3};
    endfunction

    function void write_reg(logic idx, logic [31:0] data);
      if (idx == CFG_START_SEQ) begin
        start_seq = data;
        seq_word  = data;
      end else begin
        start_ctr = data;
        ctr_word  = data;
      end
    endfunction

    // Queue the value a request produces and advance the counter state
    function void note_request(func_t f, logic [63:0] idx);
      logic [63:0] v;
      v = '0;
      case (f)
        FUNC_NEXT32, FUNC_NEXT64: begin
          v = hash_pair(seq_word, ctr_word);
          if (f == FUNC_NEXT32) v[63:32] = '0;
          ctr_word = ctr_word + 32'd1;
          if (ctr_word == '0) seq_word = seq_word + 32'd1;
        end
        FUNC_HASH: v = hash_pair(idx[63:32], idx[31:0]);
        default: v = '0;
      endcase
      expected_values.push_back(v);
    endfunction

    function int pending();
      return expected_values.size();
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      if (mismatches < PRINT_CAP)
        $display("%0t mismatch: %s got %h expected %h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_value(logic [63:0] got);
      logic [63:0] want;
      if (expected_values.size() == 0) begin
        report_mismatch("result with no request outstanding", got, '0);
      end else begin
        want = expected_values.pop_front();
        if (got !== want) report_mismatch("out_value", got, want);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_func;
  logic [63:0] in_index;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_value;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic [31:0] cfg_data;

  rng_scoreboard sb;
  int unsigned   req_gap_max;
  int unsigned   res_gap_max;
  int unsigned   cycle_count;

  pseudo_des_counter_hash_rng_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .in_index  (in_index),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_value (out_value),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Hold a request after an optional gap until its transfer, then log it
  task send_request(func_t f, logic [63:0] idx);
    int unsigned gap;
    gap = $urandom_range(0, req_gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= f;
    in_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(f, idx);
  endtask

  // Mostly valid operations with random indexes, some unused codes
  task send_random();
    func_t       f;
    logic [63:0] idx;
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 3) f = FUNC_NEXT32;
    else if (pick < 6) f = FUNC_NEXT64;
    else if (pick < 9) f = FUNC_HASH;
    else f = FUNC_NONE;
    case ($urandom_range(0, 15))
      0: idx = '0;
      1: idx = '1;
      default: idx = {$urandom(), $urandom()};
    endcase
    send_request(f, idx);
  endtask

  // Present one register write until its transfer; caller drops cfg_valid
  task write_reg(logic idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task wait_idle();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Result side: random stall per result, check each transfer
  initial begin
    int unsigned gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      gap = $urandom_range(0, res_gap_max);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      sb.check_value(out_value);
    end
  end

  initial begin
    logic [31:0] seq;
    logic [31:0] ctr;
    sb          = new();
    cycle_count = 0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_func     = FUNC_NEXT32;
    in_index    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_START_SEQ;
    cfg_data    = '0;
    req_gap_max = 0;
    res_gap_max = 3;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset state: every operation and index extremes
    send_request(FUNC_NEXT32, '0);
    send_request(FUNC_NEXT64, '1);
    send_request(FUNC_HASH, '0);
    send_request(FUNC_HASH, '1);
    send_request(FUNC_HASH, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(FUNC_HASH, 64'h5555_5555_5555_5555);
    send_request(FUNC_HASH, 64'h8000_0000_0000_0001);
    send_request(FUNC_NONE, '1);
    send_request(FUNC_NONE, '0);
    in_valid <= 1'b0;

    // Counter wrap with the sequence word at its top: both words roll over
    wait_idle();
    write_reg(CFG_START_SEQ, 32'hFFFF_FFFF);
    write_reg(CFG_START_CTR, 32'hFFFF_FFFE);
    cfg_valid <= 1'b0;
    send_request(FUNC_NEXT64, '0);
    send_request(FUNC_NEXT32, '1);
    send_request(FUNC_NEXT64, '0);
    send_request(FUNC_NEXT32, '0);
    in_valid <= 1'b0;

    // Counter wrap from a zero sequence word
    wait_idle();
    write_reg(CFG_START_SEQ, '0);
    write_reg(CFG_START_CTR, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    send_request(FUNC_NEXT32, '0);
    send_request(FUNC_NEXT64, '0);
    in_valid <= 1'b0;

    // Hash of the state pair must match the next 64-bit value
    wait_idle();
    seq = $urandom();
    ctr = $urandom();
    write_reg(CFG_START_SEQ, seq);
    write_reg(CFG_START_CTR, ctr);
    cfg_valid <= 1'b0;
    send_request(FUNC_HASH, {seq, ctr});
    send_request(FUNC_NEXT64, {seq, ctr});
    send_request(FUNC_NEXT32, '0);
    in_valid <= 1'b0;

    // Random phases with different register settings and idling profiles
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin
          seq = '0;
          ctr = '0;
          req_gap_max = GAP_MAX;
          res_gap_max = GAP_MAX;
        end
        1: begin
          seq = 32'hFFFF_FFFF;
          ctr = 32'hFFFF_FFFF - $urandom_range(0, 60);
          req_gap_max = 0;
          res_gap_max = 0;
        end
        2: begin
          seq = $urandom();
          ctr = $urandom();
          req_gap_max = GAP_MAX;
          res_gap_max = 0;
        end
        3: begin
          seq = $urandom();
          ctr = 32'hFFFF_FFFF - $urandom_range(0, 100);
          req_gap_max = 0;
          res_gap_max = GAP_MAX;
        end
        default: begin
          seq = $urandom();
          ctr = $urandom();
          req_gap_max = GAP_MAX;
          res_gap_max = GAP_MAX;
        end
      endcase
      wait_idle();
      // Counter only in phase 2: the sequence word carries over
      if (p != 2) write_reg(CFG_START_SEQ, seq);
      write_reg(CFG_START_CTR, ctr);
      cfg_valid <= 1'b0;
      repeat (PHASE_ITEMS) send_random();
      in_valid <= 1'b0;
    end

    // Drain, then give the pipeline time to show any stray result
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
